>>> rtl/core/rope_pkg.sv
// shared types, constants and coefficient functions for the rotary embedding block
package rope_pkg;

  localparam int MaxHalfDef     = 256;
  localparam int CordicStepsDef = 20;

  localparam int FracBits = 20;      // fraction bits of the exponent
  localparam int ExpW     = 33;      // pair index times log2 step
  localparam int MW       = 33;      // mantissa 2^-f, Q0.32 with room for 1.0
  localparam int PosW     = 20;
  localparam int AngW     = PosW + MW;
  localparam int QuoBits  = 19;      // quotient bits of angle / 2pi
  localparam int ResW     = 35;      // residue below 2pi
  localparam int CW       = 34;      // cordic datapath width, Q.30

  localparam longint unsigned TwoPiQ32  = 64'd26986075409;
  localparam longint unsigned PiQ32     = 64'd13493037705;
  localparam longint unsigned HalfPiQ32 = 64'd6746518852;
  localparam longint unsigned GainQ30   = 64'd652032874;
  localparam logic [24:0]     Log2StepReset = 25'd436000;

  localparam logic [29:0] AtanQ30 [30] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } pair_t;

  function automatic longint unsigned rope_isqrt(input longint unsigned num);
    longint unsigned res;
    longint unsigned b;
    longint unsigned n;
    res = 0;
    n   = num;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // c_k = 2^(-2^-k) in Q0.32, by repeated square roots
  function automatic logic [31:0] rate_coef(input int k);
    longint unsigned c;
    c = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      c = rope_isqrt(c << 32);
    end
    return c[31:0];
  endfunction

endpackage

>>> rtl/core/rope_if.sv
// valid/ready channel interfaces for input items, results and configuration
interface rope_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elem_lo;
  logic signed [31:0] elem_hi;
  logic [7:0]         pair_index;
  logic [19:0]        position;
  modport source (output valid, elem_lo, elem_hi, pair_index, position, input ready);
  modport sink   (input valid, elem_lo, elem_hi, pair_index, position, output ready);
endinterface

interface rope_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotated_lo;
  logic signed [31:0] rotated_hi;
  logic               saturated;
  modport source (output valid, rotated_lo, rotated_hi, saturated, input ready);
  modport sink   (input valid, rotated_lo, rotated_hi, saturated, output ready);
endinterface

interface rope_cfg_if;
  logic        valid;
  logic        ready;
  logic [24:0] log2_step;
  modport source (output valid, log2_step, input ready);
  modport sink   (input valid, log2_step, output ready);
endinterface

>>> rtl/core/rope_rate.sv
// exponent, rate 2^-e and angle = position * rate, at most one multiply per stage
module rope_rate #(
  parameter int MAX_HALF = rope_pkg::MaxHalfDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  rope_pkg::pair_t          pair_i,
  input  logic [7:0]               idx_i,
  input  logic [rope_pkg::PosW-1:0] pos_i,
  input  logic [24:0]              step_i,
  output logic                     valid_o,
  output rope_pkg::pair_t          pair_o,
  output logic [rope_pkg::AngW-1:0] angle_o
);
  import rope_pkg::*;

  localparam int NS = FracBits + 1;

  logic            vld_q  [NS];
  logic [ExpW-1:0] e_q    [NS];
  logic [MW-1:0]   m_q    [NS];
  logic [PosW-1:0] pos_q  [NS];
  pair_t           pair_q [NS];

  logic [7:0]      idx_c;
  logic [ExpW-1:0] e_d;

  assign idx_c = ({1'b0, idx_i} >= 9'(MAX_HALF)) ? 8'(MAX_HALF - 1) : idx_i;
  assign e_d   = ExpW'(idx_c) * ExpW'(step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0]    <= e_d;
      m_q[0]    <= MW'(64'd1 << 32);
      pos_q[0]  <= pos_i;
      pair_q[0] <= pair_i;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_mant
    localparam logic [31:0] Ck = rate_coef(k);
    logic [MW+31:0] prod;
    assign prod = (MW + 32)'(m_q[k-1]) * (MW + 32)'(Ck);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]    <= e_q[k-1][FracBits-k] ? prod[MW+31:32] : m_q[k-1];
        e_q[k]    <= e_q[k-1];
        pos_q[k]  <= pos_q[k-1];
        pair_q[k] <= pair_q[k-1];
      end
    end
  end

  // integer part of the exponent shifts the mantissa down
  logic [ExpW-FracBits-1:0] shamt;
  logic [MW-1:0]            rate_d, rate_q;
  logic [PosW-1:0]          rpos_q;
  pair_t                    rpair_q;
  logic                     rvld_q, avld_q;
  logic [AngW-1:0]          ang_q;
  pair_t                    apair_q;

  assign shamt  = e_q[NS-1][ExpW-1:FracBits];
  assign rate_d = (shamt >= (ExpW - FracBits)'(MW)) ? '0 : (m_q[NS-1] >> shamt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
      avld_q <= 1'b0;
    end else if (en_i) begin
      rvld_q <= vld_q[NS-1];
      avld_q <= rvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rate_q  <= rate_d;
      rpos_q  <= pos_q[NS-1];
      rpair_q <= pair_q[NS-1];
      ang_q   <= AngW'(rpos_q) * AngW'(rate_q);
      apair_q <= rpair_q;
    end
  end

  assign valid_o = avld_q;
  assign pair_o  = apair_q;
  assign angle_o = ang_q;

endmodule

>>> rtl/core/rope_mod.sv
// angle modulo 2pi by restoring subtraction, then fold into [-pi/2, pi/2]
module rope_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rope_pkg::pair_t           pair_i,
  input  logic [rope_pkg::AngW-1:0] angle_i,
  output logic                      valid_o,
  output rope_pkg::pair_t           pair_o,
  output logic                      neg_o,
  output logic signed [rope_pkg::CW-1:0] z_o
);
  import rope_pkg::*;

  localparam logic signed [ResW:0] TwoPiS  = (ResW + 1)'(TwoPiQ32);
  localparam logic signed [ResW:0] PiS     = (ResW + 1)'(PiQ32);
  localparam logic signed [ResW:0] HalfPiS = (ResW + 1)'(HalfPiQ32);

  logic            vld_q  [QuoBits];
  logic [AngW-1:0] a_q    [QuoBits];
  pair_t           pair_q [QuoBits];

  for (genvar s = 0; s < QuoBits; s++) begin : g_div
    localparam logic [AngW-1:0] Dv = AngW'(TwoPiQ32) << (QuoBits - 1 - s);
    logic            vin;
    logic [AngW-1:0] ain;
    pair_t           pin;
    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign ain = angle_i;
      assign pin = pair_i;
    end else begin : g_next
      assign vin = vld_q[s-1];
      assign ain = a_q[s-1];
      assign pin = pair_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s]    <= (ain >= Dv) ? ain - Dv : ain;
        pair_q[s] <= pin;
      end
    end
  end

  logic signed [ResW:0] res, s1_q, s1_d;
  logic                 v1_q, v2_q, neg_d, neg_q;
  pair_t                p1_q, p2_q;
  logic signed [ResW:0] f_d;
  logic signed [CW-1:0] z_q;

  assign res  = $signed({1'b0, a_q[QuoBits-1][ResW-1:0]});
  assign s1_d = (res > PiS) ? res - TwoPiS : res;

  always_comb begin
    neg_d = 1'b0;
    f_d   = s1_q;
    if (s1_q > HalfPiS) begin
      f_d   = s1_q - PiS;
      neg_d = 1'b1;
    end else if (s1_q < -HalfPiS) begin
      f_d   = s1_q + PiS;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_q[QuoBits-1];
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      p1_q  <= pair_q[QuoBits-1];
      z_q   <= CW'(f_d >>> 2);
      neg_q <= neg_d;
      p2_q  <= p1_q;
    end
  end

  assign valid_o = v2_q;
  assign pair_o  = p2_q;
  assign neg_o   = neg_q;
  assign z_o     = z_q;

endmodule

>>> rtl/core/rope_cordic.sv
// rotation-mode cordic, one micro-rotation per pipeline stage
module rope_cordic #(
  parameter int CORDIC_STEPS = rope_pkg::CordicStepsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  rope_pkg::pair_t                pair_i,
  input  logic                           neg_i,
  input  logic signed [rope_pkg::CW-1:0] z_i,
  output logic                           valid_o,
  output rope_pkg::pair_t                pair_o,
  output logic                           neg_o,
  output logic signed [rope_pkg::CW-1:0] cos_o,
  output logic signed [rope_pkg::CW-1:0] sin_o
);
  import rope_pkg::*;

  logic                 vld_q  [CORDIC_STEPS];
  logic                 neg_q  [CORDIC_STEPS];
  pair_t                pair_q [CORDIC_STEPS];
  logic signed [CW-1:0] x_q    [CORDIC_STEPS];
  logic signed [CW-1:0] y_q    [CORDIC_STEPS];
  logic signed [CW-1:0] z_q    [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [CW-1:0] At = CW'(AtanQ30[k]);
    logic                 vin, nin;
    pair_t                pin;
    logic signed [CW-1:0] xin, yin, zin, dx, dy;
    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign nin = neg_i;
      assign pin = pair_i;
      assign xin = CW'(GainQ30);
      assign yin = '0;
      assign zin = z_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign nin = neg_q[k-1];
      assign pin = pair_q[k-1];
      assign xin = x_q[k-1];
      assign yin = y_q[k-1];
      assign zin = z_q[k-1];
    end
    assign dx = yin >>> k;
    assign dy = xin >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k]  <= nin;
        pair_q[k] <= pin;
        if (!zin[CW-1]) begin
          x_q[k] <= xin - dx;
          y_q[k] <= yin + dy;
          z_q[k] <= zin - At;
        end else begin
          x_q[k] <= xin + dx;
          y_q[k] <= yin - dy;
          z_q[k] <= zin + At;
        end
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STEPS-1];
  assign pair_o  = pair_q[CORDIC_STEPS-1];
  assign neg_o   = neg_q[CORDIC_STEPS-1];
  assign cos_o   = x_q[CORDIC_STEPS-1];
  assign sin_o   = y_q[CORDIC_STEPS-1];

endmodule

>>> rtl/core/rope_rot.sv
// plane rotation of the pair: sign fix, products, sums, rounding and clamping
module rope_rot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  rope_pkg::pair_t                pair_i,
  input  logic                           neg_i,
  input  logic signed [rope_pkg::CW-1:0] cos_i,
  input  logic signed [rope_pkg::CW-1:0] sin_i,
  output logic                           valid_o,
  output logic signed [31:0]             rot_lo_o,
  output logic signed [31:0]             rot_hi_o,
  output logic                           sat_o
);
  import rope_pkg::*;

  localparam int PW = 32 + CW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] Half   = SW'(64'd1 << 29);
  localparam logic signed [SW-1:0] SatMax = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SatMin = -SW'(64'sd2147483648);

  logic                 v1_q, v2_q, v3_q, v4_q;
  pair_t                p1_q;
  logic signed [CW-1:0] cs_q, sn_q;
  logic signed [PW-1:0] lc_q, hs_q, hc_q, ls_q;
  logic signed [SW-1:0] s0_q, s1_q, r0, r1;
  logic signed [31:0]   o0_q, o1_q;
  logic                 sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign r0 = (s0_q + Half) >>> 30;
  assign r1 = (s1_q + Half) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q  <= neg_i ? -cos_i : cos_i;
      sn_q  <= neg_i ? -sin_i : sin_i;
      p1_q  <= pair_i;
      lc_q  <= PW'(p1_q.lo) * PW'(cs_q);
      hs_q  <= PW'(p1_q.hi) * PW'(sn_q);
      hc_q  <= PW'(p1_q.hi) * PW'(cs_q);
      ls_q  <= PW'(p1_q.lo) * PW'(sn_q);
      s0_q  <= SW'(lc_q) - SW'(hs_q);
      s1_q  <= SW'(hc_q) + SW'(ls_q);
      o0_q  <= (r0 > SatMax) ? 32'sh7fffffff : (r0 < SatMin) ? 32'sh80000000 : r0[31:0];
      o1_q  <= (r1 > SatMax) ? 32'sh7fffffff : (r1 < SatMin) ? 32'sh80000000 : r1[31:0];
      sat_q <= (r0 > SatMax) || (r0 < SatMin) || (r1 > SatMax) || (r1 < SatMin);
    end
  end

  assign valid_o  = v4_q;
  assign rot_lo_o = o0_q;
  assign rot_hi_o = o1_q;
  assign sat_o    = sat_q;

endmodule

>>> rtl/core/rotary_position_embedding.sv
// rotary position embedding, rotate-half pairs, fully pipelined
// pipeline stages in order: rate/angle, modulo/fold, one per cordic step, rotation; the
// mantissa multiply chain, the modulo and the cordic throughput one item per cycle;
// the whole pipe holds while the result is not taken
// reset clears every valid bit and sets log2_step to 436000
module rotary_position_embedding #(
  parameter int MAX_HALF     = rope_pkg::MaxHalfDef,
  parameter int CORDIC_STEPS = rope_pkg::CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rope_in_if.sink    in_i,
  rope_cfg_if.sink   cfg_i,
  rope_out_if.source out_o
);
  import rope_pkg::*;

  logic        en;
  logic [24:0] log2_step_q;

  assign en          = !out_o.valid || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_step_q <= Log2StepReset;
    end else if (cfg_i.valid) begin
      log2_step_q <= cfg_i.log2_step;
    end
  end

  pair_t                pair_in, pair_a, pair_m, pair_c;
  logic                 v_a, v_m, v_c, neg_m, neg_c;
  logic [AngW-1:0]      angle;
  logic signed [CW-1:0] z, cs, sn;

  assign pair_in.lo = in_i.elem_lo;
  assign pair_in.hi = in_i.elem_hi;

  rope_rate #(.MAX_HALF(MAX_HALF)) u_rate (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_i.valid), .pair_i(pair_in), .idx_i(in_i.pair_index),
    .pos_i(in_i.position), .step_i(log2_step_q),
    .valid_o(v_a), .pair_o(pair_a), .angle_o(angle)
  );

  rope_mod u_mod (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_a), .pair_i(pair_a), .angle_i(angle),
    .valid_o(v_m), .pair_o(pair_m), .neg_o(neg_m), .z_o(z)
  );

  rope_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_m), .pair_i(pair_m), .neg_i(neg_m), .z_i(z),
    .valid_o(v_c), .pair_o(pair_c), .neg_o(neg_c), .cos_o(cs), .sin_o(sn)
  );

  rope_rot u_rot (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_c), .pair_i(pair_c), .neg_i(neg_c), .cos_i(cs), .sin_i(sn),
    .valid_o(out_o.valid), .rot_lo_o(out_o.rotated_lo),
    .rot_hi_o(out_o.rotated_hi), .sat_o(out_o.saturated)
  );

endmodule
